[src/ltp_pkg.sv]
package ltp_pkg;

  localparam int unsigned DEF_NONTERMINAL_COUNT = 32;
  localparam int unsigned DEF_TERMINAL_COUNT    = 32;
  localparam int unsigned DEF_RULE_COUNT        = 64;
  localparam int unsigned DEF_RHS_MAX           = 8;
  localparam int unsigned DEF_STACK_SIZE        = 64;

  localparam logic [5:0] START_RESET = 6'd32;

  // action codes
  localparam logic [2:0] ACT_LOAD_TABLE = 3'd0;
  localparam logic [2:0] ACT_LOAD_SYM   = 3'd1;
  localparam logic [2:0] ACT_SET_LEN    = 3'd2;
  localparam logic [2:0] ACT_START      = 3'd3;
  localparam logic [2:0] ACT_TOKEN      = 3'd4;

  // result status codes
  localparam logic [2:0] ST_LOADED      = 3'd0;
  localparam logic [2:0] ST_CONSUMED    = 3'd1;
  localparam logic [2:0] ST_ACCEPTED    = 3'd2;
  localparam logic [2:0] ST_REJECTED    = 3'd3;
  localparam logic [2:0] ST_NOT_STARTED = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] nonterminal;
    logic [4:0] terminal;
    logic [5:0] rule_number;
    logic [2:0] position;
    logic [5:0] symbol;
    logic [3:0] rule_length;
    logic [4:0] token;
    logic       last_token;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] stack_depth;
  } out_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_ACCEPT,
    PH_REJECT
  } phase_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_TOP,
    S_ENTRY,
    S_LEN,
    S_PUSH,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_POP,
    OP_TOP,
    OP_ENTRY,
    OP_LEN,
    OP_PUSH,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic go_run;
    logic sp_zero;
    logic expand;
    logic entry_ok;
    logic ovf;
    logic len_zero;
    logic k_last;
    logic slot_free;
  } sts_t;

endpackage

[src/ll1_table_parser.sv]
// Sequence: loads, start and ignored tokens go from the idle state to the done state, then emit.
// A live token repeats a pop and stack read, then a match (terminal) or a table read, length
// read and one push per symbol (expansion of an L-symbol rule), until a match, an empty stack or a reject.
// Flow: one item at a time; a new transfer is taken once the result is offered.
// A load passes through the idle and done states only. A stalled result holds the next one back.
// Reset: async active low; a clearing pass then zeroes every entry of the parse table.
module ll1_table_parser #(
  parameter int unsigned NONTERMINAL_COUNT = ltp_pkg::DEF_NONTERMINAL_COUNT,
  parameter int unsigned TERMINAL_COUNT    = ltp_pkg::DEF_TERMINAL_COUNT,
  parameter int unsigned RULE_COUNT        = ltp_pkg::DEF_RULE_COUNT,
  parameter int unsigned RHS_MAX           = ltp_pkg::DEF_RHS_MAX,
  parameter int unsigned STACK_SIZE        = ltp_pkg::DEF_STACK_SIZE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // item input channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ltp_pkg::in_t  in_data_i,
  // result channel, registered
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ltp_pkg::out_t out_data_o,
  // start symbol register
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_wdata_i
);

  ltp_pkg::cmd_t cmd;
  ltp_pkg::sts_t sts;

  // controller sequences pop, table lookup and pushes; datapath owns stack and tables
  ltp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o
  );

  ltp_dp #(
    .NONTERMINAL_COUNT (NONTERMINAL_COUNT),
    .TERMINAL_COUNT    (TERMINAL_COUNT),
    .RULE_COUNT        (RULE_COUNT),
    .RHS_MAX           (RHS_MAX),
    .STACK_SIZE        (STACK_SIZE)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

`ifndef SYNTHESIS
  // an accepted transfer always leaves the block busy in the cycle after it
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a result is only emitted when the output slot can take it
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == ltp_pkg::OP_EMIT) |-> sts.slot_free)
    else $error("result emitted into a full output slot");

  // a rule expansion with symbols that fit on the stack always goes on to push them
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == ltp_pkg::OP_LEN && !sts.ovf && !sts.len_zero) |=> (cmd.op == ltp_pkg::OP_PUSH))
    else $error("rule expansion lost its push phase");
`endif

endmodule

[src/ltp_ram.sv]
module ltp_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 64,
  parameter int unsigned AW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ltp_ctrl.sv]
module ltp_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  ltp_pkg::sts_t sts_i,
  output ltp_pkg::cmd_t cmd_o,
  output logic         in_stall_o
);

  ltp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ltp_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ltp_pkg::OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ltp_pkg::S_CLEAR: begin
        cmd_o.op = ltp_pkg::OP_CLEAR;
        if (sts_i.clr_last) state_d = ltp_pkg::S_IDLE;
      end
      ltp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = ltp_pkg::OP_ACCEPT;
          state_d  = sts_i.go_run ? ltp_pkg::S_POP : ltp_pkg::S_DONE;
        end
      end
      ltp_pkg::S_POP: begin
        cmd_o.op = ltp_pkg::OP_POP;
        state_d  = sts_i.sp_zero ? ltp_pkg::S_DONE : ltp_pkg::S_TOP;
      end
      ltp_pkg::S_TOP: begin
        cmd_o.op = ltp_pkg::OP_TOP;
        state_d  = sts_i.expand ? ltp_pkg::S_ENTRY : ltp_pkg::S_DONE;
      end
      ltp_pkg::S_ENTRY: begin
        cmd_o.op = ltp_pkg::OP_ENTRY;
        state_d  = sts_i.entry_ok ? ltp_pkg::S_LEN : ltp_pkg::S_DONE;
      end
      ltp_pkg::S_LEN: begin
        cmd_o.op = ltp_pkg::OP_LEN;
        if (sts_i.ovf) begin
          state_d = ltp_pkg::S_DONE;
        end else if (sts_i.len_zero) begin
          state_d = ltp_pkg::S_POP;
        end else begin
          state_d = ltp_pkg::S_PUSH;
        end
      end
      ltp_pkg::S_PUSH: begin
        cmd_o.op = ltp_pkg::OP_PUSH;
        if (sts_i.k_last) state_d = ltp_pkg::S_POP;
      end
      ltp_pkg::S_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.op = ltp_pkg::OP_EMIT;
          state_d  = ltp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ltp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[src/ltp_dp.sv]
module ltp_dp #(
  parameter int unsigned NONTERMINAL_COUNT = ltp_pkg::DEF_NONTERMINAL_COUNT,
  parameter int unsigned TERMINAL_COUNT    = ltp_pkg::DEF_TERMINAL_COUNT,
  parameter int unsigned RULE_COUNT        = ltp_pkg::DEF_RULE_COUNT,
  parameter int unsigned RHS_MAX           = ltp_pkg::DEF_RHS_MAX,
  parameter int unsigned STACK_SIZE        = ltp_pkg::DEF_STACK_SIZE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ltp_pkg::cmd_t cmd_i,
  output ltp_pkg::sts_t sts_o,
  input  ltp_pkg::in_t  in_data_i,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_wdata_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ltp_pkg::out_t out_data_o
);

  localparam int unsigned TBL_D     = NONTERMINAL_COUNT * TERMINAL_COUNT;
  localparam int unsigned TBL_AW    = $clog2(TBL_D);
  localparam int unsigned SYM_D     = RULE_COUNT * RHS_MAX;
  localparam int unsigned SYM_AW    = $clog2(SYM_D);
  localparam int unsigned RULE_AW   = $clog2(RULE_COUNT);
  localparam int unsigned SAW       = $clog2(STACK_SIZE);
  localparam int unsigned SPW       = $clog2(STACK_SIZE + 1);
  localparam int unsigned KW        = $clog2(RHS_MAX + 1);
  localparam int unsigned EXP_LIMIT = (NONTERMINAL_COUNT + 1) * (STACK_SIZE + RHS_MAX);
  localparam int unsigned EW        = $clog2(EXP_LIMIT + 1);

  logic [SPW-1:0]     sp_q, sp_d;
  ltp_pkg::phase_e    phase_q, phase_d;
  logic [5:0]         start_q;
  logic [4:0]         tok_q, tok_d;
  logic               final_q, final_d;
  logic [EW-1:0]      exp_q, exp_d;
  logic [5:0]         entry_q, entry_d;
  logic [KW-1:0]      k_q, k_d;
  logic [TBL_AW-1:0]  clr_q, clr_d;
  logic [2:0]         res_q, res_d;
  logic               out_vld_q, out_vld_d;
  ltp_pkg::out_t      out_q, out_d;
  logic [RULE_COUNT-1:0] len_vld_q, len_vld_d;
  logic               len_vld_rd_q;

  // memory ports
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [5:0]        tbl_wdata, tbl_rd;
  logic              sym_we;
  logic [SYM_AW-1:0] sym_waddr, sym_raddr;
  logic [5:0]        sym_rd;
  logic              len_we;
  logic [RULE_AW-1:0] len_waddr, len_raddr;
  logic [3:0]        len_wdata, len_rd;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [5:0]        stk_wdata, stk_rd;

  logic [5:0]        top;
  logic              top_term, row_ok;
  logic [3:0]        len_eff;
  logic [KW-1:0]     k_rd;
  logic [RULE_AW-1:0] ridx;

  assign top      = stk_rd;
  assign top_term = !top[5];
  assign row_ok   = int'(top[4:0]) < NONTERMINAL_COUNT;
  assign len_eff  = len_vld_rd_q ? len_rd : 4'd0;
  assign ridx     = RULE_AW'(entry_q);

  assign sts_o.clr_last  = clr_q == TBL_AW'(TBL_D - 1);
  assign sts_o.go_run    = (in_data_i.action == ltp_pkg::ACT_TOKEN) && (phase_q == ltp_pkg::PH_RUN)
                           && (int'(in_data_i.token) < TERMINAL_COUNT);
  assign sts_o.sp_zero   = sp_q == '0;
  assign sts_o.expand    = !top_term && row_ok;
  assign sts_o.entry_ok  = (tbl_rd != '0) && (int'(tbl_rd) < RULE_COUNT) && (int'(exp_q) != EXP_LIMIT);
  assign sts_o.ovf       = (int'(sp_q) + int'(len_eff)) > STACK_SIZE;
  assign sts_o.len_zero  = len_eff == '0;
  assign sts_o.k_last    = k_q == KW'(1);
  assign sts_o.slot_free = !out_vld_q || !out_stall_i;

  always_comb begin
    sp_d      = sp_q;
    phase_d   = phase_q;
    tok_d     = tok_q;
    final_d   = final_q;
    exp_d     = exp_q;
    entry_d   = entry_q;
    k_d       = k_q;
    clr_d     = clr_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    len_vld_d = len_vld_q;
    k_rd      = '0;

    tbl_we    = 1'b0;
    tbl_waddr = TBL_AW'(int'(in_data_i.nonterminal) * TERMINAL_COUNT + int'(in_data_i.terminal));
    tbl_wdata = in_data_i.rule_number;
    tbl_raddr = TBL_AW'(int'(top[4:0]) * TERMINAL_COUNT + int'(tok_q));
    sym_we    = 1'b0;
    sym_waddr = SYM_AW'(int'(in_data_i.rule_number) * RHS_MAX + int'(in_data_i.position));
    len_we    = 1'b0;
    len_waddr = RULE_AW'(in_data_i.rule_number);
    len_wdata = (int'(in_data_i.rule_length) > RHS_MAX) ? 4'(RHS_MAX) : in_data_i.rule_length;
    len_raddr = RULE_AW'(tbl_rd);
    stk_we    = 1'b0;
    stk_waddr = SAW'(sp_q);
    stk_wdata = sym_rd;
    stk_raddr = SAW'(sp_q - SPW'(1));

    case (cmd_i.op)
      ltp_pkg::OP_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
        clr_d     = clr_q + TBL_AW'(1);
      end
      ltp_pkg::OP_ACCEPT: begin
        tok_d   = in_data_i.token;
        final_d = in_data_i.last_token;
        exp_d   = '0;
        res_d   = ltp_pkg::ST_LOADED;
        case (in_data_i.action)
          ltp_pkg::ACT_LOAD_TABLE: begin
            tbl_we = (int'(in_data_i.nonterminal) < NONTERMINAL_COUNT)
                     && (int'(in_data_i.terminal) < TERMINAL_COUNT);
          end
          ltp_pkg::ACT_LOAD_SYM: begin
            sym_we = (int'(in_data_i.rule_number) < RULE_COUNT)
                     && (int'(in_data_i.position) < RHS_MAX);
          end
          ltp_pkg::ACT_SET_LEN: begin
            if (int'(in_data_i.rule_number) < RULE_COUNT) begin
              len_we               = 1'b1;
              len_vld_d[len_waddr] = 1'b1;
            end
          end
          ltp_pkg::ACT_START: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = start_q;
            sp_d      = SPW'(1);
            phase_d   = ltp_pkg::PH_RUN;
          end
          ltp_pkg::ACT_TOKEN: begin
            case (phase_q)
              ltp_pkg::PH_IDLE:   res_d = ltp_pkg::ST_NOT_STARTED;
              ltp_pkg::PH_ACCEPT: res_d = ltp_pkg::ST_ACCEPTED;
              ltp_pkg::PH_REJECT: res_d = ltp_pkg::ST_REJECTED;
              default: begin
                // token code beyond the terminal set rejects at once
                if (!sts_o.go_run) begin
                  phase_d = ltp_pkg::PH_REJECT;
                  res_d   = ltp_pkg::ST_REJECTED;
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      ltp_pkg::OP_POP: begin
        if (sts_o.sp_zero) begin
          phase_d = ltp_pkg::PH_ACCEPT;
          res_d   = ltp_pkg::ST_ACCEPTED;
        end else begin
          sp_d = sp_q - SPW'(1);
        end
      end
      ltp_pkg::OP_TOP: begin
        if (top_term) begin
          if (top != {1'b0, tok_q}) begin
            phase_d = ltp_pkg::PH_REJECT;
            res_d   = ltp_pkg::ST_REJECTED;
          end else if (sts_o.sp_zero) begin
            phase_d = ltp_pkg::PH_ACCEPT;
            res_d   = ltp_pkg::ST_ACCEPTED;
          end else if (final_q) begin
            phase_d = ltp_pkg::PH_REJECT;
            res_d   = ltp_pkg::ST_REJECTED;
          end else begin
            res_d = ltp_pkg::ST_CONSUMED;
          end
        end else if (!row_ok) begin
          phase_d = ltp_pkg::PH_REJECT;
          res_d   = ltp_pkg::ST_REJECTED;
        end
      end
      ltp_pkg::OP_ENTRY: begin
        if (!sts_o.entry_ok) begin
          phase_d = ltp_pkg::PH_REJECT;
          res_d   = ltp_pkg::ST_REJECTED;
        end else begin
          exp_d   = exp_q + EW'(1);
          entry_d = tbl_rd;
        end
      end
      ltp_pkg::OP_LEN: begin
        if (sts_o.ovf) begin
          phase_d = ltp_pkg::PH_REJECT;
          res_d   = ltp_pkg::ST_REJECTED;
        end else begin
          k_d  = KW'(len_eff);
          k_rd = KW'(len_eff) - KW'(1);
        end
      end
      ltp_pkg::OP_PUSH: begin
        // symbols go on reversed: slot k-1 first, next read overlaps this write
        stk_we = 1'b1;
        sp_d   = sp_q + SPW'(1);
        k_d    = k_q - KW'(1);
        k_rd   = k_q - KW'(2);
      end
      ltp_pkg::OP_EMIT: begin
        out_vld_d         = 1'b1;
        out_d.status      = res_q;
        out_d.stack_depth = 7'(sp_q);
      end
      default: begin
      end
    endcase

    sym_raddr = SYM_AW'(int'(ridx) * RHS_MAX + int'(k_rd));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      phase_q   <= ltp_pkg::PH_IDLE;
      start_q   <= ltp_pkg::START_RESET;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      len_vld_q <= '0;
      exp_q     <= '0;
      k_q       <= '0;
    end else begin
      sp_q      <= sp_d;
      phase_q   <= phase_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      len_vld_q <= len_vld_d;
      exp_q     <= exp_d;
      k_q       <= k_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q        <= tok_d;
    final_q      <= final_d;
    entry_q      <= entry_d;
    res_q        <= res_d;
    out_q        <= out_d;
    len_vld_rd_q <= len_vld_q[len_raddr];
  end

  ltp_ram #(.W(6), .D(TBL_D)) u_tbl (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr), .rdata_o(tbl_rd)
  );

  ltp_ram #(.W(6), .D(SYM_D)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(in_data_i.symbol),
    .raddr_i(sym_raddr), .rdata_o(sym_rd)
  );

  ltp_ram #(.W(4), .D(RULE_COUNT)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rd)
  );

  ltp_ram #(.W(6), .D(STACK_SIZE)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[tb/ll1_table_parser_test.sv]
`timescale 1ns / 100ps

module ll1_table_parser_test;
  import ltp_pkg::*;

  localparam int unsigned NT_COUNT   = DEF_NONTERMINAL_COUNT;
  localparam int unsigned T_COUNT    = DEF_TERMINAL_COUNT;
  localparam int unsigned RULES      = DEF_RULE_COUNT;
  localparam int unsigned RHS_SLOTS  = DEF_RHS_MAX;
  localparam int unsigned STACK_MAX  = DEF_STACK_SIZE;
  // left-recursive tables spin until this many expansions for one token
  localparam int unsigned EXPAND_CAP = (NT_COUNT + 1) * (STACK_MAX + RHS_SLOTS);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;

  ll1_table_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow parser state, updated as each item transfer is taken
  logic [5:0] parse_tbl [NT_COUNT*T_COUNT];
  logic [5:0] rhs_syms  [RULES*RHS_SLOTS];
  logic [3:0] rhs_len   [RULES];
  logic [5:0] sym_stack [STACK_MAX];
  int unsigned depth;
  phase_e     phase;
  logic [5:0] start_sym;

  out_t pending_results[$];
  int   errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  typedef struct {
    in_t        it;
    bit         typed;
    logic [2:0] st;
    logic [6:0] dp;
  } dir_row_t;
  dir_row_t dir_rows[$];

  // Consume one token against the shadow stack; returns the new phase.
  function automatic phase_e match_token(logic [4:0] tok, logic fin);
    int unsigned n;
    int unsigned len;
    logic [5:0] top;
    logic [5:0] ent;
    n = 0;
    forever begin
      if (depth == 0) return PH_ACCEPT;
      depth--;
      top = sym_stack[depth];
      if (top < 6'd32) begin
        if (top[4:0] != tok) return PH_REJECT;
        break;
      end
      ent = parse_tbl[{top[4:0], tok}];
      if (ent == 6'd0) return PH_REJECT;
      n++;
      if (n > EXPAND_CAP) return PH_REJECT;
      len = rhs_len[ent];
      if (depth + len > STACK_MAX) return PH_REJECT;
      // right-hand side goes on reversed so its first symbol ends on top
      for (int k = len; k > 0; k--) begin
        sym_stack[depth] = rhs_syms[{ent, 3'(k - 1)}];
        depth++;
      end
    end
    if (depth == 0) return PH_ACCEPT;
    if (fin) return PH_REJECT;
    return PH_RUN;
  endfunction

  function automatic out_t parse_step(in_t it);
    out_t r;
    r.status = ST_LOADED;
    case (it.action)
      ACT_LOAD_TABLE: parse_tbl[{it.nonterminal, it.terminal}] = it.rule_number;
      ACT_LOAD_SYM:   rhs_syms[{it.rule_number, it.position}] = it.symbol;
      ACT_SET_LEN:    rhs_len[it.rule_number] = (it.rule_length > 4'd8) ? 4'd8
                                                                         : it.rule_length;
      ACT_START: begin
        sym_stack[0] = start_sym;
        depth = 1;
        phase = PH_RUN;
      end
      ACT_TOKEN: begin
        if (phase == PH_IDLE) r.status = ST_NOT_STARTED;
        else if (phase == PH_ACCEPT) r.status = ST_ACCEPTED;
        else if (phase == PH_REJECT) r.status = ST_REJECTED;
        else begin
          phase = match_token(it.token, it.last_token);
          case (phase)
            PH_ACCEPT: r.status = ST_ACCEPTED;
            PH_REJECT: r.status = ST_REJECTED;
            default:   r.status = ST_CONSUMED;
          endcase
        end
      end
      default: ;
    endcase
    r.stack_depth = depth[6:0];
    return r;
  endfunction

  // Drive one item; valid stays high afterwards until the caller drops it.
  task automatic send_item(in_t it, bit typed = 0, out_t typed_res = '0);
    out_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    r = parse_step(it);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_start(logic [5:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_sym = v;
  endtask

  function automatic in_t mk(logic [2:0] a, logic [4:0] nt, logic [4:0] te, logic [5:0] ru,
                             logic [2:0] po, logic [5:0] sy, logic [3:0] ln,
                             logic [4:0] tk, logic ls);
    in_t it;
    it.action = a; it.nonterminal = nt; it.terminal = te; it.rule_number = ru;
    it.position = po; it.symbol = sy; it.rule_length = ln; it.token = tk;
    it.last_token = ls;
    return it;
  endfunction

  function automatic void add_row(in_t it, bit typed = 0, logic [2:0] st = '0,
                                  logic [6:0] dp = '0);
    dir_row_t row;
    row = '{it, typed, st, dp};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Random item; while a parse runs, tokens mostly follow the shadow stack
  // so that parses get past the first expansions.
  function automatic in_t rand_item();
    in_t it;
    logic [5:0] top;
    int unsigned c0;
    it = in_t'({$urandom, $urandom});
    if (phase == PH_RUN && depth != 0 && $urandom_range(99) < 70) begin
      it.action = ACT_TOKEN;
      it.last_token = ($urandom_range(7) == 0);
      top = sym_stack[depth-1];
      if ($urandom_range(9) != 0) begin
        if (top < 6'd32) it.token = top[4:0];
        else begin
          c0 = $urandom_range(31);
          for (int i = 0; i < 32; i++)
            if (parse_tbl[{top[4:0], 5'((c0 + i) % 32)}] != 6'd0) begin
              it.token = 5'((c0 + i) % 32);
              break;
            end
        end
      end
      return it;
    end
    case ($urandom_range(19))
      0, 1, 2, 3: begin
        it.action = ACT_LOAD_TABLE;
        if ($urandom_range(9) == 0) it.rule_number = '0;
      end
      4, 5, 6: begin
        it.action = ACT_LOAD_SYM;
        if ($urandom_range(1)) it.symbol[5] = 1'b0;
      end
      7, 8: begin
        it.action = ACT_SET_LEN;
        // mostly short rules, now and then any 4-bit size, saturating ones included
        if ($urandom_range(5) != 0) it.rule_length = 4'($urandom_range(3));
      end
      9, 10, 11, 12: it.action = ACT_START;
      13, 14, 15, 16, 17: it.action = ACT_TOKEN;
      default: it.action = 3'($urandom_range(5, 7));
    endcase
    return it;
  endfunction

  // result side: check every transfer, stall at random
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: %p", out_data_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.stack_depth !== exp_res.stack_depth) begin
          $error("stack_depth: expected %0d, actual %0d",
                 exp_res.stack_depth, out_data_o.stack_depth);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int i = 0; i < NT_COUNT*T_COUNT; i++) parse_tbl[i] = '0;
    for (int i = 0; i < RULES*RHS_SLOTS; i++) rhs_syms[i] = '0;
    for (int i = 0; i < RULES; i++) rhs_len[i] = '0;
    for (int i = 0; i < STACK_MAX; i++) sym_stack[i] = '0;
    depth = 0;
    phase = PH_IDLE;
    start_sym = START_RESET;

    // Directed rows; start symbol is the reset value 32 (row 0).
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 5, 0), 1, ST_NOT_STARTED, 0);
    add_row(mk(3'd7, 31, 31, 63, 7, 63, 15, 31, 1), 1, ST_LOADED, 0);
    add_row(mk(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_LOADED, 1);
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_REJECTED, 0); // error entry
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 3, 0), 1, ST_REJECTED, 0); // after reject
    add_row(mk(ACT_LOAD_TABLE, 0, 3, 1, 0, 0, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_LOAD_SYM, 0, 0, 1, 0, 3, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_LOAD_SYM, 0, 0, 1, 1, 33, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_SET_LEN, 0, 0, 1, 0, 0, 2, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_LOAD_TABLE, 1, 31, 63, 0, 0, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_SET_LEN, 0, 0, 63, 0, 0, 0, 0, 0), 1, ST_LOADED, 0);  // empty rule
    add_row(mk(ACT_SET_LEN, 0, 0, 2, 0, 0, 15, 0, 0), 1, ST_LOADED, 0);  // saturates
    add_row(mk(ACT_LOAD_TABLE, 31, 0, 63, 0, 0, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_LOAD_SYM, 0, 0, 63, 7, 63, 0, 0, 0), 1, ST_LOADED, 0);
    add_row(mk(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_LOADED, 1);
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 3, 0));                      // expand + match
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 31, 1), 1, ST_ACCEPTED, 0);  // empty rule
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 7, 0), 1, ST_ACCEPTED, 0);   // after accept
    add_row(mk(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_LOADED, 1);
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 3, 1), 1, ST_REJECTED, 1);   // leftover
    add_row(mk(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_LOADED, 1);
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 31, 0), 1, ST_REJECTED, 0);
    add_row(mk(ACT_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_REJECTED, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 10;
    rx_idle_pct = 85;
    foreach (dir_rows[i])
      send_item(dir_rows[i].it, dir_rows[i].typed, '{dir_rows[i].st, dir_rows[i].dp});

    // every rule slot gets written so no expansion reads an unwritten one
    for (int r = 0; r < RULES; r++)
      for (int p = 0; p < RHS_SLOTS; p++)
        send_item(mk(ACT_LOAD_SYM, 5'($urandom), 5'($urandom), 6'(r), 3'(p),
                     $urandom_range(1) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(31)),
                     4'($urandom), 5'($urandom), 1'($urandom)));

    for (int ph = 0; ph < 3; ph++) begin
      drain();  // sender holds off until all results are in
      case (ph)
        0: write_start(6'd63);
        1: begin
          write_start(6'($urandom_range(33, 62)));
          tx_idle_pct = 85;
          rx_idle_pct = 10;
        end
        default: begin
          write_start(6'd32);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (470) send_item(rand_item());
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
src/ltp_pkg.sv
src/ltp_ram.sv
src/ltp_ctrl.sv
src/ltp_dp.sv
src/ll1_table_parser.sv
tb/ll1_table_parser_test.sv
